[src/sle_pkg.sv]
// Shared types and constants for the sorted list engine.
`timescale 1ns / 1ps
package sle_pkg;

  localparam int DATA_W       = 32;
  localparam int REQ_W        = 3;
  localparam int STAT_W       = 3;
  localparam int CAPACITY_DEF = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT    = 3'd0,
    REQ_REMOVE    = 3'd1,
    REQ_CLEAR     = 3'd2,
    REQ_DUMP_ASC  = 3'd3,
    REQ_DUMP_DESC = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_VALUE   = 3'd0,
    ST_DONE    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_MISSING = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_OP,
    FSM_LIST
  } fsm_state_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROT_L,
    CELL_ROT_R
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0] key;
  } cell_cmd_t;

endpackage

[src/sle_in_if.sv]
// Request channel: valid/ready handshake with request code and operand.
`timescale 1ns / 1ps
interface sle_in_if;
  import sle_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [DATA_W-1:0]  value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

[src/sle_out_if.sv]
// Result channel: valid/ready handshake with value, status and last flag.
`timescale 1ns / 1ps
interface sle_out_if;
  import sle_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  out_value;
  logic [STAT_W-1:0]         status;
  logic                      last;

  modport source (output valid, output out_value, output status, output last, input ready);
  modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

[src/sle_cell.sv]
// One slot of the sorted chain: holds a value and trades with its neighbours.
`timescale 1ns / 1ps
module sle_cell (
  input  logic                              clk,
  input  sle_pkg::cell_cmd_t                cmd,
  input  logic                              occ,
  input  logic                              is_end,
  input  logic                              is_tail,
  input  logic signed [sle_pkg::DATA_W-1:0] left_val,
  input  logic                              left_cond,
  input  logic signed [sle_pkg::DATA_W-1:0] right_val,
  input  logic signed [sle_pkg::DATA_W-1:0] wrap_val,
  output logic signed [sle_pkg::DATA_W-1:0] value,
  output logic                              ins_cond,
  output logic                              match
);
  import sle_pkg::*;

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;
  logic                     del_shift;

  assign value = value_r;
  // Key goes at or before this slot: slot is the first free one or holds a larger value.
  assign ins_cond  = is_end | (occ & (cmd.key < value_r));
  assign match     = occ & (value_r == cmd.key);
  // Entries at or after the first copy of the key close up the gap.
  assign del_shift = occ & !(value_r < cmd.key);

  always_comb begin
    value_nxt = value_r;
    case (cmd.op)
      CELL_INSERT: begin
        if (left_cond) begin
          value_nxt = left_val;
        end else if (ins_cond) begin
          value_nxt = cmd.key;
        end
      end
      CELL_REMOVE: begin
        if (del_shift) begin
          value_nxt = right_val;
        end
      end
      CELL_ROT_L: begin
        if (occ) begin
          value_nxt = is_tail ? wrap_val : right_val;
        end
      end
      CELL_ROT_R: begin
        if (occ) begin
          value_nxt = left_val;
        end
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

[src/sorted_list_engine_core.sv]
// Top level of the sorted list engine: control sequencer over a chain of cells.
`timescale 1ns / 1ps
// Insert and remove pass through the operation state and present their status item from
// the output register. Requests are handled one at a time, each taken only when idle.
// Clear and dumps: one item per stored entry, one per cycle unless the result side stalls,
// after a pass through the operation state; an empty list gives a single status item.
// Reset empties the list (count to zero) and clears control; cell contents are not reset.
module sorted_list_engine_core #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  sle_in_if.sink    in_ch,
  sle_out_if.source out_ch
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Control registers
  fsm_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         step_r, step_nxt;
  req_t                     req_r;
  logic signed [DATA_W-1:0] key_r;

  // Output register
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     out_load;
  logic                     out_free;

  // Chain signals
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_val   [CAPACITY];
  logic signed [DATA_W-1:0] left_vals  [CAPACITY];
  logic signed [DATA_W-1:0] right_vals [CAPACITY];
  logic [CAPACITY-1:0]      cell_cond;
  logic [CAPACITY-1:0]      left_conds;
  logic [CAPACITY-1:0]      cell_match;
  logic [CAPACITY-1:0]      cell_occ;
  logic [CAPACITY-1:0]      cell_end;
  logic [CAPACITY-1:0]      cell_tail;
  logic signed [DATA_W-1:0] tail_val;
  logic                     found;
  logic                     in_accept;
  logic                     list_last;

  assign in_accept = in_ch.valid & in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign found     = |cell_match;
  assign list_last = (step_r == (count_r - CNT_W'(1)));

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_value = out_value_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.last      = out_last_r;

  // Build the chain; each cell sees only its neighbours, the key and its place
  // relative to the fill count. Cell 0 wraps to the tail for right rotation,
  // the tail cell wraps to the head for left rotation.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_occ[i]  = CNT_W'(i) < count_r;
    assign cell_end[i]  = CNT_W'(i) == count_r;
    assign cell_tail[i] = CNT_W'(i + 1) == count_r;

    if (i == 0) begin : g_first
      assign left_vals[i]  = tail_val;
      assign left_conds[i] = 1'b0;
    end else begin : g_inner
      assign left_vals[i]  = cell_val[i-1];
      assign left_conds[i] = cell_cond[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_vals[i] = cell_val[i];
    end else begin : g_body
      assign right_vals[i] = cell_val[i+1];
    end

    sle_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (cell_occ[i]),
      .is_end    (cell_end[i]),
      .is_tail   (cell_tail[i]),
      .left_val  (left_vals[i]),
      .left_cond (left_conds[i]),
      .right_val (right_vals[i]),
      .wrap_val  (cell_val[0]),
      .value     (cell_val[i]),
      .ins_cond  (cell_cond[i]),
      .match     (cell_match[i])
    );
  end

  // Pick the tail value with a one-hot AND-OR
  always_comb begin
    tail_val = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (cell_tail[k]) begin
        tail_val = tail_val | cell_val[k];
      end
    end
  end

  // Sequencer: next state, chain command and result loading
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    cmd.op         = CELL_HOLD;
    cmd.key        = key_r;
    out_load       = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = ST_DONE;
    out_last_nxt   = 1'b1;
    in_ch.ready    = 1'b0;

    case (state_r)
      FSM_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_accept) begin
          case (req_t'(in_ch.req_type))
            REQ_INSERT, REQ_REMOVE, REQ_CLEAR, REQ_DUMP_ASC, REQ_DUMP_DESC: begin
              state_nxt = FSM_OP;
            end
            default: begin
              // Unused code: drop the item silently
              state_nxt = FSM_IDLE;
            end
          endcase
        end
      end

      FSM_OP: begin
        if (out_free) begin
          state_nxt = FSM_IDLE;
          out_load  = 1'b1;
          case (req_r)
            REQ_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                out_status_nxt = ST_FULL;
              end else begin
                cmd.op    = CELL_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_REMOVE: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else if (!found) begin
                out_status_nxt = ST_MISSING;
              end else begin
                cmd.op    = CELL_REMOVE;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            REQ_CLEAR, REQ_DUMP_ASC, REQ_DUMP_DESC: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                // Move to the list state to stream the entries
                out_load  = 1'b0;
                state_nxt = FSM_LIST;
                step_nxt  = '0;
              end
            end
            default: begin
              out_load = 1'b0;
            end
          endcase
        end
      end

      FSM_LIST: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = ST_VALUE;
          out_last_nxt   = list_last;
          step_nxt       = step_r + CNT_W'(1);
          // Emit the head and rotate left, or the tail and rotate right;
          // a full turn leaves the list as it was.
          if (req_r == REQ_DUMP_DESC) begin
            out_value_nxt = tail_val;
            cmd.op        = CELL_ROT_R;
          end else begin
            out_value_nxt = cell_val[0];
            cmd.op        = CELL_ROT_L;
          end
          if (list_last) begin
            state_nxt = FSM_IDLE;
            if (req_r == REQ_CLEAR) begin
              count_nxt = '0;
            end
          end
        end
      end

      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: latch the request and the result item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r <= req_t'(in_ch.req_type);
      key_r <= in_ch.value;
    end
    if (out_load) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_status_nxt == ST_FULL) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status with free slots");

  a_list_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_LIST) |-> (count_r != '0))
    else $error("listing an empty chain");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_last_nxt && state_r == FSM_LIST && req_r == REQ_CLEAR)
      |=> (count_r == '0))
    else $error("clear left entries behind");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_IDLE && count_r >= CNT_W'(2)) |-> (cell_val[0] <= cell_val[1]))
    else $error("chain head out of order");

endmodule

[bench/tb.sv]
// Self-checking bench for the sorted list engine: random requests, mirrored list, item check.
`timescale 1ns / 1ps
module tb;
  import sle_pkg::*;

  localparam int CAP           = CAPACITY_DEF;
  localparam int RANDOM_ITEMS  = 370;
  localparam int CYCLE_LIMIT   = 800000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RESET_CYCLES  = 12;
  localparam int MAX_REPORTS   = 40;
  localparam int POOL_SIZE     = 6;

  // Request codes the block must ignore.
  localparam logic [REQ_W-1:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_LAST  = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [REQ_W-1:0]         code;
    logic signed [DATA_W-1:0] operand;
    bit                       drain_first;   // hold until every awaited item has come
  } request_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic                     last;
  } list_item_t;

  // Ways the result side accepts items.
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sle_in_if  in_ch ();
  sle_out_if out_ch ();

  sorted_list_engine_core #(
    .CAPACITY(CAP)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  request_t                 req_backlog[$];   // requests still to be offered
  list_item_t               awaited_items[$]; // items the list should still send, oldest first
  logic signed [DATA_W-1:0] list_mirror[$];   // our own copy of the sorted contents
  logic signed [DATA_W-1:0] operand_pool[POOL_SIZE];

  int         fail_count = 0;
  int         cycle_count = 0;
  int         stim_count = 0;
  bit         drain_pending = 1'b0;
  logic       items_drained;      // registered: nothing awaited after the last edge
  int         burst_left;
  int         gap_left;
  sink_mode_t sink_mode;
  int         sink_left;
  request_t   next_req;
  list_item_t head_item;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: mirror the sorted multiset and queue the items each request owes.
  // ---------------------------------------------------------------------------
  function automatic void await_item(input logic signed [DATA_W-1:0] v, input status_t st,
                                     input logic lst);
    list_item_t it;
    it.value  = v;
    it.status = st;
    it.last   = lst;
    awaited_items.push_back(it);
  endfunction

  // One value item per entry, or a single empty status when nothing is stored.
  function automatic void await_listing(input bit descending);
    int n;
    n = list_mirror.size();
    if (n == 0) begin
      await_item('0, ST_EMPTY, 1'b1);
    end else begin
      for (int i = 0; i < n; i++)
        await_item(descending ? list_mirror[n-1-i] : list_mirror[i], ST_VALUE, i == n - 1);
    end
  endfunction

  function automatic void track_request(input logic [REQ_W-1:0] code,
                                        input logic signed [DATA_W-1:0] v);
    int p;
    p = 0;
    case (code)
      REQ_INSERT: begin
        if (list_mirror.size() >= CAP) begin
          // full: drop the value, list untouched
          await_item('0, ST_FULL, 1'b1);
        end else begin
          // place after any equal values so duplicates sit side by side
          while (p < list_mirror.size() && !(v < list_mirror[p])) p++;
          list_mirror.insert(p, v);
          await_item('0, ST_DONE, 1'b1);
        end
      end
      REQ_REMOVE: begin
        if (list_mirror.size() == 0) begin
          await_item('0, ST_EMPTY, 1'b1);
        end else begin
          while (p < list_mirror.size() && list_mirror[p] != v) p++;
          if (p == list_mirror.size()) begin
            await_item('0, ST_MISSING, 1'b1);
          end else begin
            list_mirror.delete(p);
            await_item('0, ST_DONE, 1'b1);
          end
        end
      end
      REQ_CLEAR: begin
        // deleted values come out in ascending order, then the list is empty
        await_listing(1'b0);
        list_mirror.delete();
      end
      REQ_DUMP_ASC:  await_listing(1'b0);
      REQ_DUMP_DESC: await_listing(1'b1);
      default: ;  // spare codes: no item, no change
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function automatic void add_request(input logic [REQ_W-1:0] code,
                                      input logic signed [DATA_W-1:0] operand);
    request_t r;
    r.code        = code;
    r.operand     = operand;
    r.drain_first = drain_pending;
    drain_pending = 1'b0;
    req_backlog.push_back(r);
    // ignored requests do not count towards the random quota
    if (code <= REQ_DUMP_DESC) stim_count++;
  endfunction

  // Mostly pool values so removes find their target; corners and fresh noise besides.
  function automatic logic signed [DATA_W-1:0] draw_operand();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return -1;
      3:       return $urandom;
      default: return operand_pool[$urandom_range(0, POOL_SIZE - 1)];
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer items in bursts with random gaps; hold an item while it
  // waits for ready, and hold a draining item until the list has gone quiet.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (req_backlog.size() != 0 &&
                   (!req_backlog[0].drain_first || (!in_ch.valid && items_drained))) begin
        next_req = req_backlog.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= next_req.code;
        in_ch.value    <= next_req.operand;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          // new burst; a third of the time run back to back with no gap
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: switch between stall patterns, each held for a random stretch.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (sink_left == 0) begin
        sink_mode = sink_mode_t'($urandom_range(SINK_OPEN, SINK_PERIODIC));
        sink_left = $urandom_range(40, 300);
      end else begin
        sink_left--;
      end
      case (sink_mode)
        SINK_OPEN:   out_ch.ready <= 1'b1;
        SINK_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        SINK_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:     out_ch.ready <= ((cycle_count % 7) < 4);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted request, then check every accepted item
  // against the oldest one awaited. Both in one block so the order is fixed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        track_request(in_ch.req_type, in_ch.value);
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_items.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $error("unexpected item: out_value %0d status %0d last %0d",
                   out_ch.out_value, out_ch.status, out_ch.last);
        end else begin
          head_item = awaited_items.pop_front();
          if (out_ch.out_value !== head_item.value) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("out_value: expected %0d, got %0d", head_item.value, out_ch.out_value);
          end
          if (out_ch.status !== head_item.status) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("status: expected %0d, got %0d", head_item.status, out_ch.status);
          end
          if (out_ch.last !== head_item.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $error("last: expected %0d, got %0d", head_item.last, out_ch.last);
          end
        end
      end
    end
    items_drained <= (awaited_items.size() == 0);
  end

  // Watchdog: abandon the run well past the slowest correct finish.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Build the stimulus, release reset, wait for the list to go quiet.
  // ---------------------------------------------------------------------------
  initial begin
    int span;
    int pick;
    in_ch.valid    = 1'b0;
    in_ch.req_type = REQ_INSERT;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;
    items_drained  = 1'b1;
    burst_left     = 0;
    gap_left       = 0;
    sink_mode      = SINK_OPEN;
    sink_left      = 0;

    // Directed: every request on an empty list, spare codes, corner values,
    // duplicates, both dumps, absent and present removes, clear with content.
    add_request(REQ_DUMP_ASC, '0);
    add_request(REQ_DUMP_DESC, '0);
    add_request(REQ_CLEAR, '0);
    add_request(REQ_REMOVE, '0);
    for (int c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++) add_request(REQ_W'(c), VAL_MAX);
    add_request(REQ_INSERT, VAL_MAX);
    add_request(REQ_INSERT, VAL_MIN);
    add_request(REQ_INSERT, -1);
    add_request(REQ_INSERT, 0);
    add_request(REQ_INSERT, 1);
    add_request(REQ_INSERT, -1);
    add_request(REQ_DUMP_ASC, VAL_MIN);
    add_request(REQ_DUMP_DESC, VAL_MAX);
    add_request(REQ_REMOVE, 12345);
    add_request(REQ_REMOVE, -1);
    add_request(REQ_REMOVE, VAL_MIN);
    add_request(REQ_REMOVE, VAL_MAX);
    add_request(REQ_DUMP_DESC, '0);
    add_request(REQ_CLEAR, -1);
    add_request(REQ_DUMP_ASC, '0);

    // Random episodes; the first always starts from a drained list.
    stim_count    = 0;
    drain_pending = 1'b1;
    while (stim_count < RANDOM_ITEMS) begin
      foreach (operand_pool[k]) operand_pool[k] = $urandom;
      if ($urandom_range(0, 2) == 0) drain_pending = 1'b1;
      case ($urandom_range(0, 5))
        0, 1: begin
          // fill past capacity so the drop path is hit, list, prune, clear
          span = CAP + $urandom_range(1, 4);
          repeat (span) add_request(REQ_INSERT, draw_operand());
          add_request($urandom_range(0, 1) ? REQ_DUMP_ASC : REQ_DUMP_DESC, $urandom);
          repeat ($urandom_range(2, 8)) add_request(REQ_REMOVE, draw_operand());
          add_request(REQ_CLEAR, $urandom);
        end
        2, 3, 4: begin
          // mixed traffic over a small set of values
          span = $urandom_range(10, 40);
          repeat (span) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      add_request(REQ_INSERT, draw_operand());
            else if (pick < 78) add_request(REQ_REMOVE, draw_operand());
            else if (pick < 86) add_request(REQ_DUMP_ASC, $urandom);
            else if (pick < 94) add_request(REQ_DUMP_DESC, $urandom);
            else if (pick < 97) add_request(REQ_CLEAR, $urandom);
            else add_request(REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST)),
                             $urandom);
          end
        end
        default: begin
          // noise: any code, any operand
          repeat ($urandom_range(3, 10)) add_request(REQ_W'($urandom_range(0, 7)), $urandom);
        end
      endcase
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (req_backlog.size() != 0 || in_ch.valid || awaited_items.size() != 0);
    // allow any stray item to surface
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/sle_pkg.sv
src/sle_in_if.sv
src/sle_out_if.sv
src/sle_cell.sv
src/sorted_list_engine_core.sv
bench/tb.sv
